### rtl/waypoint_follower_controller_macros.svh
// Assertion macros for the waypoint follower controller checker.
// Needs clk and arst_n in the scope of each use.
`ifndef WAYPOINT_FOLLOWER_CONTROLLER_MACROS_SVH
`define WAYPOINT_FOLLOWER_CONTROLLER_MACROS_SVH

// clocked, held off during reset
`define WFC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// clocked, also checked during reset
`define WFC_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/wfc_pkg.sv
// Shared types, constants and functions of the waypoint follower controller.
// No dependencies; used by every module of the block.
package wfc_pkg;

	localparam int MAX_WAYPOINTS = 16;
	localparam int CORDIC_STEPS  = 16;
	localparam int WP_AW   = $clog2(MAX_WAYPOINTS);
	localparam int CNT_W   = $clog2(MAX_WAYPOINTS + 1);
	localparam int ITER_W  = $clog2(CORDIC_STEPS);
	localparam int CX_W    = 36;
	localparam int CZ_W    = 28;
	localparam int ANG_W   = 18;
	localparam int NUM_REGS = 6;
	localparam int APB_AW  = $clog2(NUM_REGS * 4);

	localparam int PI_Q13      = 25736;
	localparam int TWO_PI_Q13  = 51472;
	localparam int HALF_PI_Q24 = 26353589;
	localparam int GAIN_Q30    = 652032874;

	typedef enum logic [1:0] {
		CMD_LOAD  = 2'd0,
		CMD_START = 2'd1,
		CMD_STEP  = 2'd2,
		CMD_NOP   = 2'd3
	} cmd_t;

	typedef enum logic [APB_AW-3:0] {
		REG_THETA_THR = 3'd0,
		REG_DIST_THR  = 3'd1,
		REG_LIN_LIM   = 3'd2,
		REG_ANG_LIM   = 3'd3,
		REG_WP_COUNT  = 3'd4,
		REG_START_HDG = 3'd5
	} reg_idx_t;

	typedef struct packed {
		cmd_t               command;
		logic [3:0]         waypoint_index;
		logic signed [31:0] waypoint_x;
		logic signed [31:0] waypoint_y;
	} in_beat_t;

	typedef struct packed {
		logic [30:0]        linear_cmd;
		logic signed [15:0] angular_cmd;
		logic               target_reached;
		logic [3:0]         target_index;
		logic signed [31:0] position_x;
		logic signed [31:0] position_y;
		logic signed [15:0] heading_out;
	} out_beat_t;

	typedef struct packed {
		logic [14:0]        theta_threshold;
		logic [30:0]        distance_threshold;
		logic [30:0]        linear_limit;
		logic [14:0]        angular_limit;
		logic [4:0]         waypoint_count;
		logic signed [15:0] start_heading;
	} cfg_t;

	typedef struct packed {
		logic              capture;
		logic              load_wr;
		logic              mod_sub;
		logic              rd_en;
		logic              rd_zero;
		logic              start_apply;
		logic              prep;
		logic              v_iter;
		logic              mag1;
		logic              mag2;
		logic              decide;
		logic              r_init;
		logic              r_iter;
		logic              mulx;
		logic              muly;
		logic              head;
		logic              res_load;
		logic [ITER_W-1:0] iter;
	} dp_cmd_t;

	typedef struct packed {
		logic tp_ge_n;
		logic drive;
	} dp_sts_t;

	// atan(2^-i) in Q.24
	function automatic logic signed [CZ_W-1:0] atan_q24(input logic [4:0] i);
		logic signed [CZ_W-1:0] r;
		case (i)
			5'd0:  r = CZ_W'(13176795);
			5'd1:  r = CZ_W'(7778716);
			5'd2:  r = CZ_W'(4110060);
			5'd3:  r = CZ_W'(2086331);
			5'd4:  r = CZ_W'(1047214);
			5'd5:  r = CZ_W'(524117);
			5'd6:  r = CZ_W'(262123);
			5'd7:  r = CZ_W'(131069);
			5'd8:  r = CZ_W'(65536);
			5'd9:  r = CZ_W'(32768);
			5'd10: r = CZ_W'(16384);
			5'd11: r = CZ_W'(8192);
			5'd12: r = CZ_W'(4096);
			5'd13: r = CZ_W'(2048);
			5'd14: r = CZ_W'(1024);
			5'd15: r = CZ_W'(512);
			5'd16: r = CZ_W'(256);
			5'd17: r = CZ_W'(128);
			5'd18: r = CZ_W'(64);
			5'd19: r = CZ_W'(32);
			5'd20: r = CZ_W'(16);
			5'd21: r = CZ_W'(8);
			5'd22: r = CZ_W'(4);
			5'd23: r = CZ_W'(2);
			5'd24: r = CZ_W'(1);
			default: r = '0;
		endcase
		return r;
	endfunction

	// fold into (-pi, pi]
	function automatic logic signed [ANG_W-1:0] wrap_ang(input logic signed [ANG_W-1:0] a);
		logic signed [ANG_W-1:0] r;
		r = a;
		if (r > ANG_W'(PI_Q13)) r = r - ANG_W'(TWO_PI_Q13);
		if (r > ANG_W'(PI_Q13)) r = r - ANG_W'(TWO_PI_Q13);
		if (r <= -ANG_W'(PI_Q13)) r = r + ANG_W'(TWO_PI_Q13);
		if (r <= -ANG_W'(PI_Q13)) r = r + ANG_W'(TWO_PI_Q13);
		return r;
	endfunction

endpackage

### rtl/wfc_regs.sv
// Configuration register file on an APB-style port.
// Depends on wfc_pkg.
module wfc_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [wfc_pkg::APB_AW-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	output wfc_pkg::cfg_t              cfg
);
	import wfc_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr;

	assign idx    = reg_idx_t'(paddr[APB_AW-1:2]);
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.theta_threshold    <= 15'd819;
			cfg_q.distance_threshold <= 31'd6554;
			cfg_q.linear_limit       <= 31'd65536;
			cfg_q.angular_limit      <= 15'd8192;
			cfg_q.waypoint_count     <= 5'd1;
			cfg_q.start_heading      <= '0;
		end else if (wr) begin
			case (idx)
				REG_THETA_THR: cfg_q.theta_threshold    <= pwdata[14:0];
				REG_DIST_THR:  cfg_q.distance_threshold <= pwdata[30:0];
				REG_LIN_LIM:   cfg_q.linear_limit       <= pwdata[30:0];
				REG_ANG_LIM:   cfg_q.angular_limit      <= pwdata[14:0];
				REG_WP_COUNT:  cfg_q.waypoint_count     <= pwdata[4:0];
				REG_START_HDG: cfg_q.start_heading      <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_THETA_THR: prdata = {17'd0, cfg_q.theta_threshold};
			REG_DIST_THR:  prdata = {1'b0, cfg_q.distance_threshold};
			REG_LIN_LIM:   prdata = {1'b0, cfg_q.linear_limit};
			REG_ANG_LIM:   prdata = {17'd0, cfg_q.angular_limit};
			REG_WP_COUNT:  prdata = {27'd0, cfg_q.waypoint_count};
			REG_START_HDG: prdata = {16'd0, cfg_q.start_heading};
			default:       prdata = '0;
		endcase
	end

endmodule

### rtl/wfc_ctrl.sv
// Sequencer: one-hot state machine that steps the datapath through a command.
// Depends on wfc_pkg.
module wfc_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	output logic             cmd_stall,
	input  wfc_pkg::cmd_t    command,
	output logic             res_valid,
	input  logic             res_stall,
	output wfc_pkg::dp_cmd_t dp_cmd,
	input  wfc_pkg::dp_sts_t dp_sts
);
	import wfc_pkg::*;

	typedef enum logic [15:0] {
		S_IDLE   = 16'h0001,
		S_LOAD   = 16'h0002,
		S_MOD    = 16'h0004,
		S_READ   = 16'h0008,
		S_STRT   = 16'h0010,
		S_PREP   = 16'h0020,
		S_VITER  = 16'h0040,
		S_MAG1   = 16'h0080,
		S_MAG2   = 16'h0100,
		S_DECIDE = 16'h0200,
		S_RINIT  = 16'h0400,
		S_RITER  = 16'h0800,
		S_MULX   = 16'h1000,
		S_MULY   = 16'h2000,
		S_HEAD   = 16'h4000,
		S_DONE   = 16'h8000
	} state_t;

	state_t            state_q, state_d;
	cmd_t              op_q;
	logic [ITER_W-1:0] iter_q;
	logic              res_valid_q;
	logic              accept, last_iter, out_free;

	assign accept    = cmd_valid && (state_q == S_IDLE);
	assign cmd_stall = (state_q != S_IDLE);
	assign last_iter = (iter_q == ITER_W'(CORDIC_STEPS - 1));
	assign out_free  = !res_valid_q || !res_stall;
	assign res_valid = res_valid_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					case (command)
						CMD_LOAD:  state_d = S_LOAD;
						CMD_START: state_d = S_READ;
						CMD_STEP:  state_d = S_MOD;
						default:   state_d = S_DONE;
					endcase
				end
			end
			S_LOAD:   state_d = S_DONE;
			S_MOD:    if (!dp_sts.tp_ge_n) state_d = S_READ;
			S_READ:   state_d = (op_q == CMD_START) ? S_STRT : S_PREP;
			S_STRT:   state_d = S_DONE;
			S_PREP:   state_d = S_VITER;
			S_VITER:  if (last_iter) state_d = S_MAG1;
			S_MAG1:   state_d = S_MAG2;
			S_MAG2:   state_d = S_DECIDE;
			S_DECIDE: state_d = dp_sts.drive ? S_RINIT : S_HEAD;
			S_RINIT:  state_d = S_RITER;
			S_RITER:  if (last_iter) state_d = S_MULX;
			S_MULX:   state_d = S_MULY;
			S_MULY:   state_d = S_HEAD;
			S_HEAD:   state_d = S_DONE;
			S_DONE:   if (out_free) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= CMD_NOP;
			iter_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) op_q <= command;
			if (state_q == S_PREP || state_q == S_RINIT)
				iter_q <= '0;
			else if (state_q == S_VITER || state_q == S_RITER)
				iter_q <= iter_q + 1'b1;
			if (state_q == S_DONE && out_free)
				res_valid_q <= 1'b1;
			else if (!res_stall)
				res_valid_q <= 1'b0;
		end
	end

	always_comb begin
		dp_cmd             = '0;
		dp_cmd.capture     = accept;
		dp_cmd.load_wr     = (state_q == S_LOAD);
		dp_cmd.mod_sub     = (state_q == S_MOD) && dp_sts.tp_ge_n;
		dp_cmd.rd_en       = (state_q == S_READ);
		dp_cmd.rd_zero     = (op_q == CMD_START);
		dp_cmd.start_apply = (state_q == S_STRT);
		dp_cmd.prep        = (state_q == S_PREP);
		dp_cmd.v_iter      = (state_q == S_VITER);
		dp_cmd.mag1        = (state_q == S_MAG1);
		dp_cmd.mag2        = (state_q == S_MAG2);
		dp_cmd.decide      = (state_q == S_DECIDE);
		dp_cmd.r_init      = (state_q == S_RINIT);
		dp_cmd.r_iter      = (state_q == S_RITER);
		dp_cmd.mulx        = (state_q == S_MULX);
		dp_cmd.muly        = (state_q == S_MULY);
		dp_cmd.head        = (state_q == S_HEAD);
		dp_cmd.res_load    = (state_q == S_DONE) && out_free;
		dp_cmd.iter        = iter_q;
	end

endmodule

### rtl/wfc_dp.sv
// Datapath: waypoint memory, pose registers, shared CORDIC unit, decision
// logic and pose update multipliers. Depends on wfc_pkg.
module wfc_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  wfc_pkg::dp_cmd_t   cmd,
	output wfc_pkg::dp_sts_t   sts,
	input  wfc_pkg::cfg_t      cfg,
	input  wfc_pkg::in_beat_t  in_beat,
	output wfc_pkg::out_beat_t res_beat
);
	import wfc_pkg::*;

	localparam logic signed [CZ_W-1:0] HALF_Z = CZ_W'(HALF_PI_Q24);
	localparam logic signed [CX_W-1:0] GAIN_X = CX_W'(GAIN_Q30);
	localparam logic [29:0]            GAIN_M = 30'(GAIN_Q30);

	logic [63:0] mem [MAX_WAYPOINTS];
	logic [63:0] rd_q;

	in_beat_t                 in_q;
	logic [WP_AW-1:0]         tp_q;
	logic signed [31:0]       pose_x_q, pose_y_q;
	logic signed [15:0]       head_q;
	logic signed [CX_W-1:0]   cx_q, cy_q;
	logic signed [CZ_W-1:0]   cz_q;
	logic                     zv_q;
	logic signed [ANG_W-1:0]  err_q;
	logic [66:0]              acc_q;
	logic [30:0]              lin_q;
	logic signed [15:0]       ang_q;
	logic                     reached_q;
	logic signed [63:0]       prod_q;
	out_beat_t                res_q;

	logic [CNT_W-1:0]         n;
	logic signed [31:0]       wpx, wpy;
	logic signed [32:0]       dx, dy;
	logic signed [CX_W-1:0]   xs, ys, nx, ny;
	logic signed [CZ_W-1:0]   at, nz, zr, zround;
	logic                     dir;
	logic signed [ANG_W-1:0]  req, err_d, hsum, hstart;
	logic [47:0]              pl;
	logic [46:0]              ph;
	logic [66:0]              accr;
	logic [34:0]              dmag;
	logic [ANG_W-1:0]         aerr;
	logic [30:0]              lin_d;
	logic signed [15:0]       ang_d;
	logic                     reached_d;
	logic [WP_AW-1:0]         tp_d, tp_inc;
	logic signed [31:0]       c32, s32, lin_s;
	logic [WP_AW-1:0]         raddr;

	function automatic logic signed [31:0] pose_step(input logic signed [31:0] p,
			input logic signed [63:0] prod);
		logic signed [63:0] r;
		logic signed [33:0] s;
		logic signed [31:0] o;
		r = (prod + 64'sd536870912) >>> 30;
		s = 34'(r) + 34'(p);
		if (s > 34'sd2147483647) o = 32'sh7FFF_FFFF;
		else if (s < -34'sd2147483648) o = 32'sh8000_0000;
		else o = 32'(s);
		return o;
	endfunction

	// effective waypoint count
	always_comb begin
		if (cfg.waypoint_count == '0) n = CNT_W'(1);
		else if (int'(cfg.waypoint_count) > MAX_WAYPOINTS) n = CNT_W'(MAX_WAYPOINTS);
		else n = CNT_W'(cfg.waypoint_count);
	end

	assign sts.tp_ge_n = int'(tp_q) >= int'(n);

	// waypoint memory
	assign raddr = cmd.rd_zero ? '0 : tp_q;

	always_ff @(posedge clk) begin
		if (cmd.load_wr && int'(in_q.waypoint_index) < MAX_WAYPOINTS)
			mem[WP_AW'(in_q.waypoint_index)] <= {in_q.waypoint_x, in_q.waypoint_y};
		if (cmd.rd_en)
			rd_q <= mem[raddr];
	end

	assign wpx = rd_q[63:32];
	assign wpy = rd_q[31:0];
	assign dx  = 33'(wpx) - 33'(pose_x_q);
	assign dy  = 33'(wpy) - 33'(pose_y_q);

	// one CORDIC micro-rotation, vectoring or rotation mode
	always_comb begin
		xs  = cx_q >>> cmd.iter;
		ys  = cy_q >>> cmd.iter;
		at  = atan_q24(5'(cmd.iter));
		dir = cmd.v_iter ? (cy_q >= 0) : (cz_q < 0);
		if (dir) begin
			nx = cx_q + ys;
			ny = cy_q - xs;
			nz = cz_q + at;
		end else begin
			nx = cx_q - ys;
			ny = cy_q + xs;
			nz = cz_q - at;
		end
	end

	assign zr     = CZ_W'(head_q) <<< 11;
	assign zround = (cz_q + CZ_W'(1024)) >>> 11;
	assign req    = zv_q ? '0 : ANG_W'(zround);
	assign err_d  = wrap_ang(req - ANG_W'(head_q));
	assign hsum   = wrap_ang(ANG_W'(head_q) + ANG_W'(ang_q));
	assign hstart = wrap_ang(ANG_W'(cfg.start_heading));

	assign pl   = cx_q[17:0] * GAIN_M;
	assign ph   = cx_q[34:18] * GAIN_M;
	assign accr = acc_q + (67'(1) << 29);
	assign dmag = zv_q ? '0 : accr[64:30];

	// rotate, drive or advance
	always_comb begin
		aerr      = (err_q < 0) ? ANG_W'(-err_q) : ANG_W'(err_q);
		lin_d     = '0;
		ang_d     = '0;
		reached_d = 1'b0;
		tp_inc    = (int'(tp_q) + 1 == int'(n)) ? '0 : WP_AW'(int'(tp_q) + 1);
		tp_d      = tp_q;
		if (aerr > ANG_W'(cfg.theta_threshold)) begin
			if (aerr >= ANG_W'(cfg.angular_limit))
				ang_d = (err_q < 0) ? -$signed({1'b0, cfg.angular_limit})
					: $signed({1'b0, cfg.angular_limit});
			else
				ang_d = 16'(err_q);
		end else if (dmag > 35'(cfg.distance_threshold)) begin
			lin_d = (dmag >= 35'(cfg.linear_limit)) ? cfg.linear_limit : dmag[30:0];
		end else begin
			tp_d      = tp_inc;
			reached_d = 1'b1;
		end
	end

	assign sts.drive = (lin_d != '0);

	assign c32   = cx_q[31:0];
	assign s32   = cy_q[31:0];
	assign lin_s = $signed({1'b0, lin_q});

	// architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tp_q     <= '0;
			pose_x_q <= '0;
			pose_y_q <= '0;
			head_q   <= '0;
		end else begin
			if (cmd.mod_sub)
				tp_q <= WP_AW'(int'(tp_q) - int'(n));
			if (cmd.start_apply) begin
				pose_x_q <= wpx;
				pose_y_q <= wpy;
				head_q   <= 16'(hstart);
				tp_q     <= (n == CNT_W'(1)) ? '0 : WP_AW'(1);
			end
			if (cmd.decide)
				tp_q <= tp_d;
			if (cmd.muly)
				pose_x_q <= pose_step(pose_x_q, prod_q);
			if (cmd.head) begin
				if (lin_q != '0)
					pose_y_q <= pose_step(pose_y_q, prod_q);
				head_q <= 16'(hsum);
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			in_q      <= in_beat;
			lin_q     <= '0;
			ang_q     <= '0;
			reached_q <= 1'b0;
		end
		if (cmd.prep) begin
			zv_q <= (dx == '0) && (dy == '0);
			if (dx < 0) begin
				if (dy >= 0) begin
					cx_q <= CX_W'(dy);
					cy_q <= -CX_W'(dx);
					cz_q <= HALF_Z;
				end else begin
					cx_q <= -CX_W'(dy);
					cy_q <= CX_W'(dx);
					cz_q <= -HALF_Z;
				end
			end else begin
				cx_q <= CX_W'(dx);
				cy_q <= CX_W'(dy);
				cz_q <= '0;
			end
		end
		if (cmd.r_init) begin
			if (zr > HALF_Z) begin
				cx_q <= '0;
				cy_q <= GAIN_X;
				cz_q <= zr - HALF_Z;
			end else if (zr < -HALF_Z) begin
				cx_q <= '0;
				cy_q <= -GAIN_X;
				cz_q <= zr + HALF_Z;
			end else begin
				cx_q <= GAIN_X;
				cy_q <= '0;
				cz_q <= zr;
			end
		end
		if (cmd.v_iter || cmd.r_iter) begin
			cx_q <= nx;
			cy_q <= ny;
			cz_q <= nz;
		end
		if (cmd.mag1) begin
			err_q <= err_d;
			acc_q <= 67'(pl);
		end
		if (cmd.mag2)
			acc_q <= acc_q + (67'(ph) << 18);
		if (cmd.decide) begin
			lin_q     <= lin_d;
			ang_q     <= ang_d;
			reached_q <= reached_d;
		end
		if (cmd.mulx)
			prod_q <= lin_s * c32;
		if (cmd.muly)
			prod_q <= lin_s * s32;
		if (cmd.res_load) begin
			res_q.linear_cmd     <= lin_q;
			res_q.angular_cmd    <= ang_q;
			res_q.target_reached <= reached_q;
			res_q.target_index   <= 4'(tp_q);
			res_q.position_x     <= pose_x_q;
			res_q.position_y     <= pose_y_q;
			res_q.heading_out    <= head_q;
		end
	end

	assign res_beat = res_q;

endmodule

### rtl/waypoint_follower_controller.sv
// A step runs the CORDIC unit in vectoring mode, and then in rotation mode only
// when it drives; before that it subtracts the waypoint count from the target
// while the count has shrunk to or under the target. Load, start and no-op skip the CORDIC.
// One beat at a time: the next beat can be taken once res_valid rises. The shared
// CORDIC unit does one micro-rotation per cycle, vectoring then rotation.
// Async active-low reset: config defaults, pose and target zero, waypoint memory unset.
module waypoint_follower_controller (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cmd_valid,
	output logic                       cmd_stall,
	input  wfc_pkg::in_beat_t          cmd_beat,
	output logic                       res_valid,
	input  logic                       res_stall,
	output wfc_pkg::out_beat_t         res_beat,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [wfc_pkg::APB_AW-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);
	import wfc_pkg::*;

	cfg_t    cfg;
	dp_cmd_t dp_cmd;
	dp_sts_t dp_sts;

	wfc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	wfc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.command   (cmd_beat.command),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.dp_cmd    (dp_cmd),
		.dp_sts    (dp_sts)
	);

	wfc_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (dp_cmd),
		.sts      (dp_sts),
		.cfg      (cfg),
		.in_beat  (cmd_beat),
		.res_beat (res_beat)
	);

endmodule

### rtl/wfc_checker.sv
// Port-level checker for the waypoint follower controller, bound to the top.
// Depends on wfc_pkg and waypoint_follower_controller_macros.svh.
`include "waypoint_follower_controller_macros.svh"

module wfc_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               res_valid,
	input logic               res_stall,
	input wfc_pkg::out_beat_t res_beat,
	input logic               pready
);
	import wfc_pkg::*;

	`WFC_ASSERT_ALWAYS(a_pready, pready, "pready dropped")
	`WFC_ASSERT(a_hold, res_valid && res_stall |=> res_valid && $stable(res_beat), "stalled beat changed")
	`WFC_ASSERT(a_drive_only, res_valid && res_beat.linear_cmd != 0 |-> res_beat.angular_cmd == 0 && !res_beat.target_reached, "drive beat also turns or advances")
	`WFC_ASSERT(a_reach_idle, res_valid && res_beat.target_reached |-> res_beat.linear_cmd == 0 && res_beat.angular_cmd == 0, "advance beat carries a motion command")
	`WFC_ASSERT(a_hdg_range, res_valid |-> res_beat.heading_out <= PI_Q13 && res_beat.heading_out > -PI_Q13, "heading outside (-pi, pi]")

endmodule

bind waypoint_follower_controller wfc_checker u_wfc_checker (.*);
